// ===== hw/rtl/sdbr_pkg.sv =====
// Shared constants, types and helpers for the dead-block replacement core.
`timescale 1ns / 1ps
`default_nettype none
package sdbr_pkg;
	localparam int SETS        = 2048;
	localparam int WAYS        = 16;
	localparam int LEADER_SETS = 32;
	localparam int SIG_BITS    = 6;

	localparam int SET_W    = $clog2(SETS);
	localparam int WAY_W    = $clog2(WAYS);
	localparam int CTR_W    = 2;
	localparam int ENT_W    = CTR_W + SIG_BITS;
	localparam int ROW_W    = WAYS * ENT_W;
	localparam int OT_DEPTH = 1 << SIG_BITS;
	localparam int SEL_W    = 10;
	localparam int PER_W    = 20;
	localparam int LFSR_W   = 16;

	localparam logic [SEL_W-1:0]  SEL_MID     = 10'd512;
	localparam logic [SEL_W-1:0]  SEL_MAX     = 10'd1023;
	localparam logic [CTR_W-1:0]  CTR_MAX     = 2'd3;
	localparam logic [PER_W-1:0]  DECAY_RESET = 20'd100000;
	localparam logic [LFSR_W-1:0] LFSR_SEED   = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS   = 16'hB400;

	localparam logic REG_DECAY = 1'b0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROW,
		ST_TRAIN,
		ST_SWP_RD,
		ST_SWP_WR
	} state_t;

	function automatic logic [CTR_W-1:0] ctr_of(input logic [ROW_W-1:0] row,
			input logic [WAY_W-1:0] w);
		return row[w*ENT_W +: CTR_W];
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/sdbr_row_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sdbr_row_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sdbr_victim.sv =====
// Victim search over one set row: first zero counter, else first smallest.
`timescale 1ns / 1ps
`default_nettype none
module sdbr_victim (
	input  wire logic [sdbr_pkg::ROW_W-1:0] row,
	output logic      [sdbr_pkg::WAY_W-1:0] victim
);
	import sdbr_pkg::*;

	logic [WAYS-1:0]  is0, is1, is2;
	logic [CTR_W-1:0] least;
	logic             found;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			is0[w] = ctr_of(row, WAY_W'(w)) == 2'd0;
			is1[w] = ctr_of(row, WAY_W'(w)) == 2'd1;
			is2[w] = ctr_of(row, WAY_W'(w)) == 2'd2;
		end
		if (|is0)      least = 2'd0;
		else if (|is1) least = 2'd1;
		else if (|is2) least = 2'd2;
		else           least = CTR_MAX;
		victim = '0;
		found  = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			if (!found && ctr_of(row, WAY_W'(w)) == least) begin
				victim = WAY_W'(w);
				found  = 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ship_dip_dead_block_replacement_core.sv =====
// Dead-block replacement core: handshakes, control sequencer and outcome table.
// Usage:
//   Input channel (in_valid/in_stall) carries one request word: mode 0 asks
//   for a victim way in set_index, mode 1 reports a hit or a fill of way.
//   Output channel (out_valid/out_stall) returns one word per request:
//   victim_way (0 for updates) and the selector value after the request.
//   Per-set state sits in one row RAM (one row per set, all ways), read
//   with registered data. A victim search or a hit reads the row, then posts
//   its result; a fill reads the row, then reads the outcome table at the
//   old signature, then posts. One request is in flight at a time.
//   A fill that falls due for decay sweeps all 2048 rows, reading each row
//   and writing it back with its counters decremented, after its result is
//   posted; intake is stalled meanwhile. After reset the row RAM is cleared
//   one row per cycle with in_stall high; APB writes are taken throughout.
//   The result sits in an output register; while out_stall is high it holds,
//   and the request in flight waits at its final step.
//   APB: decay interval register at byte address 0, pready always high.
`timescale 1ns / 1ps
`default_nettype none
module ship_dip_dead_block_replacement_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [2:0]                 paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       mode,
	input  wire logic [sdbr_pkg::SET_W-1:0] set_index,
	input  wire logic [sdbr_pkg::WAY_W-1:0] way,
	input  wire logic [5:0]                 pc_low,
	input  wire logic [5:0]                 line_addr_low,
	input  wire logic                       hit,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [3:0]                 victim_way,
	output logic      [sdbr_pkg::SEL_W-1:0] selector_value
);
	import sdbr_pkg::*;

	state_t state_q, state_d;

	logic [PER_W-1:0]    period_q, upd_cnt_q;
	logic [SEL_W-1:0]    sel_q, sel_d;
	logic [LFSR_W-1:0]   lfsr_q, lfsr_d;
	logic                mode_q, hit_q, due_q, old_zero_q;
	logic [SET_W-1:0]    set_q, row_cnt_q;
	logic [WAY_W-1:0]    way_q;
	logic [SIG_BITS-1:0] sig_q, old_sig_q;
	logic                out_valid_q;
	logic [3:0]          victim_q;

	logic [ROW_W-1:0]    row_rd, row_wd, row_dec;
	logic                row_we, row_re;
	logic [SET_W-1:0]    row_wa, row_ra;
	logic [WAY_W-1:0]    victim_c;

	logic [CTR_W-1:0]    ot_mem [OT_DEPTH];
	logic [OT_DEPTH-1:0] ot_vld_q;
	logic [CTR_W-1:0]    ot_rd_q, ot_wd;
	logic                ot_we, ot_re;
	logic [SIG_BITS-1:0] ot_wa, ot_ra;

	logic                accept, go, post;
	logic [3:0]          post_victim;
	logic [PER_W-1:0]    upd_next;
	logic                due_c;
	logic [CTR_W-1:0]    old_ctr, new_ctr;
	logic [SIG_BITS-1:0] old_sig, sig_in;
	logic                lip_leader, bip_leader, use_lip, cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_DECAY);
	assign prdata   = (paddr[2] == REG_DECAY) ? {{(32-PER_W){1'b0}}, period_q} : '0;
	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && !in_stall;
	assign go       = !out_valid_q || !out_stall;
	assign sig_in   = SIG_BITS'(pc_low ^ line_addr_low);

	assign upd_next = upd_cnt_q + 1'b1;
	assign due_c    = upd_next >= period_q;

	assign old_ctr    = ctr_of(row_rd, way_q);
	assign old_sig    = row_rd[way_q*ENT_W + CTR_W +: SIG_BITS];
	assign lip_leader = set_q < SET_W'(LEADER_SETS);
	assign bip_leader = !lip_leader && set_q >= SET_W'(SETS - LEADER_SETS);
	assign use_lip    = lip_leader || (!bip_leader && sel_q >= SEL_MID);

	sdbr_victim u_victim (
		.row    (row_rd),
		.victim (victim_c)
	);

	sdbr_row_ram #(
		.DEPTH (SETS),
		.WIDTH (ROW_W)
	) u_rows (
		.clk     (clk),
		.we      (row_we),
		.wr_addr (row_wa),
		.wr_data (row_wd),
		.re      (row_re),
		.rd_addr (row_ra),
		.rd_data (row_rd)
	);

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			row_dec[w*ENT_W +: ENT_W] = row_rd[w*ENT_W +: ENT_W];
			if (ctr_of(row_rd, WAY_W'(w)) != 2'd0) begin
				row_dec[w*ENT_W +: CTR_W] = ctr_of(row_rd, WAY_W'(w)) - 1'b1;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		lfsr_d      = lfsr_q;
		new_ctr     = '0;
		row_we      = 1'b0;
		row_wa      = set_q;
		row_wd      = row_rd;
		row_re      = 1'b0;
		row_ra      = set_index;
		ot_we       = 1'b0;
		ot_wa       = sig_q;
		ot_wd       = ot_rd_q;
		ot_re       = 1'b0;
		ot_ra       = sig_in;
		post        = 1'b0;
		post_victim = '0;
		unique case (state_q)
			ST_CLEAR: begin
				row_we = 1'b1;
				row_wa = row_cnt_q;
				row_wd = '0;
				if (row_cnt_q == SET_W'(SETS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					row_re  = 1'b1;
					ot_re   = 1'b1;
					state_d = ST_ROW;
				end
			end
			ST_ROW: begin
				if (!mode_q) begin
					if (go) begin
						post        = 1'b1;
						post_victim = 4'(victim_c);
						state_d     = ST_IDLE;
					end
				end else if (hit_q) begin
					if (go) begin
						row_we = 1'b1;
						new_ctr = (old_ctr != CTR_MAX) ? old_ctr + 1'b1 : old_ctr;
						row_wd[way_q*ENT_W +: ENT_W] = {sig_q, new_ctr};
						ot_we = 1'b1;
						ot_wd = (ot_rd_q != CTR_MAX) ? ot_rd_q + 1'b1 : ot_rd_q;
						if (lip_leader) begin
							if (sel_q != SEL_MAX) sel_d = sel_q + 1'b1;
						end else if (bip_leader) begin
							if (sel_q != '0) sel_d = sel_q - 1'b1;
						end
						post    = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					if (!(old_ctr == 2'd0 || use_lip)) begin
						lfsr_d = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);
						new_ctr = (lfsr_d[4:0] == 5'd0) ? 2'd1 : 2'd0;
					end
					row_we = 1'b1;
					row_wd[way_q*ENT_W +: ENT_W] = {sig_q, new_ctr};
					ot_re   = 1'b1;
					ot_ra   = old_sig;
					state_d = ST_TRAIN;
				end
			end
			ST_TRAIN: begin
				if (go) begin
					if (old_zero_q && ot_rd_q != '0) begin
						ot_we = 1'b1;
						ot_wa = old_sig_q;
						ot_wd = ot_rd_q - 1'b1;
					end
					post    = 1'b1;
					state_d = due_q ? ST_SWP_RD : ST_IDLE;
				end
			end
			ST_SWP_RD: begin
				row_re  = 1'b1;
				row_ra  = row_cnt_q;
				state_d = ST_SWP_WR;
			end
			ST_SWP_WR: begin
				row_we  = 1'b1;
				row_wa  = row_cnt_q;
				row_wd  = row_dec;
				state_d = (row_cnt_q == SET_W'(SETS - 1)) ? ST_IDLE : ST_SWP_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			period_q    <= DECAY_RESET;
			upd_cnt_q   <= '0;
			sel_q       <= SEL_MID;
			lfsr_q      <= LFSR_SEED;
			row_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			ot_vld_q    <= '0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			lfsr_q  <= lfsr_d;
			if (cfg_wr) period_q <= pwdata[PER_W-1:0];
			if (accept && mode) upd_cnt_q <= due_c ? '0 : upd_next;
			if (state_q == ST_CLEAR || state_q == ST_SWP_WR) begin
				row_cnt_q <= row_cnt_q + 1'b1;
			end else if (state_q == ST_TRAIN) begin
				row_cnt_q <= '0;
			end
			if (post) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (ot_we) ot_vld_q[ot_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			hit_q  <= hit;
			set_q  <= set_index;
			way_q  <= way;
			sig_q  <= sig_in;
			due_q  <= due_c;
		end
		if (state_q == ST_ROW) begin
			old_zero_q <= old_ctr == 2'd0;
			old_sig_q  <= old_sig;
		end
		if (post) begin
			victim_q <= post_victim;
		end
		if (ot_we) begin
			ot_mem[ot_wa] <= ot_wd;
		end
		if (ot_re) begin
			ot_rd_q <= ot_vld_q[ot_ra] ? ot_mem[ot_ra] : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign victim_way     = victim_q;
	assign selector_value = sel_q;
endmodule
`default_nettype wire
